// File: hdl/fsal_pkg.sv
`default_nettype none

package fsal_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINK_TIMEOUT  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMU_DEBOUNCE  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAT_CRIT_MV   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAT_CRIT_CNT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STICK_CENTER  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THROTTLE_LOW  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_FRAMES    = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOST_LIMIT    = 3'd7;

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_BOOT   = 1'b1;

    localparam logic [2:0] RC_BROWNOUT = 3'd1;
    localparam logic [2:0] RC_WDT      = 3'd4;

    localparam logic [5:0] REASON_BOOT = 6'b10_0000;

    typedef struct packed {
        logic [31:0] link_timeout_us;
        logic [7:0]  imu_debounce;
        logic [15:0] battery_critical_mv;
        logic [7:0]  battery_critical_samples;
        logic [14:0] stick_center_max;
        logic [14:0] throttle_low_max;
        logic [15:0] min_good_frames;
        logic [7:0]  lost_frame_limit;
    } t_fsal_cfg;

    typedef struct packed {
        logic        action;
        logic [2:0]  reset_cause;
        logic [3:0]  radio_flags;
        logic [15:0] roll_stick;
        logic [15:0] pitch_stick;
        logic [15:0] yaw_stick;
        logic [15:0] throttle_stick;
        logic [6:0]  imu_status;
        logic [15:0] battery_mv;
        logic [2:0]  misc_flags;
    } t_fsal_item;

    typedef struct packed {
        logic       armed;
        logic       failsafe_active;
        logic       fault_latched;
        logic       boot_latched;
        logic [5:0] reason_bits;
        logic [7:0] lost_frames;
    } t_fsal_result;

endpackage

`default_nettype wire

// File: hdl/fsal_cfg_regs.sv
`default_nettype none

module fsal_cfg_regs
    import fsal_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire [CFG_DATA_BITS-1:0]  i_cfg_data,
    output t_fsal_cfg                o_cfg
);

    t_fsal_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_timeout_us          <= 32'd100000;
            r_cfg.imu_debounce             <= 8'd3;
            r_cfg.battery_critical_mv      <= 16'd3300;
            r_cfg.battery_critical_samples <= 8'd5;
            r_cfg.stick_center_max         <= 15'd1638;
            r_cfg.throttle_low_max         <= 15'd819;
            r_cfg.min_good_frames          <= 16'd10;
            r_cfg.lost_frame_limit         <= 8'd10;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LINK_TIMEOUT: r_cfg.link_timeout_us          <= i_cfg_data[31:0];
                CFG_IMU_DEBOUNCE: r_cfg.imu_debounce             <= i_cfg_data[7:0];
                CFG_BAT_CRIT_MV:  r_cfg.battery_critical_mv      <= i_cfg_data[15:0];
                CFG_BAT_CRIT_CNT: r_cfg.battery_critical_samples <= i_cfg_data[7:0];
                CFG_STICK_CENTER: r_cfg.stick_center_max         <= i_cfg_data[14:0];
                CFG_THROTTLE_LOW: r_cfg.throttle_low_max         <= i_cfg_data[14:0];
                CFG_MIN_FRAMES:   r_cfg.min_good_frames          <= i_cfg_data[15:0];
                CFG_LOST_LIMIT:   r_cfg.lost_frame_limit         <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/fsal_guard.sv
`default_nettype none

module fsal_guard
    import fsal_pkg::*;
#(
    parameter int TIME_BITS = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  t_fsal_item          i_item,
    input  wire [TIME_BITS-1:0] i_frame_time_us,
    input  wire [TIME_BITS-1:0] i_now_us,
    input  t_fsal_cfg           i_cfg,
    output t_fsal_result        o_result
);

    logic                 r_armed, n_armed;
    logic                 r_active, n_active;
    logic                 r_latch, n_latch;
    logic                 r_boot_latch, n_boot_latch;
    logic                 r_arm_test_prev, n_arm_test_prev;
    logic                 r_switch_prev, n_switch_prev;
    logic [5:0]           r_reason, n_reason;
    logic [TIME_BITS-1:0] r_last_good, n_last_good;
    logic                 r_have_frame, n_have_frame;
    logic [15:0]          r_good_cnt, n_good_cnt;
    logic [7:0]           r_lost_cnt, n_lost_cnt;
    logic [7:0]           r_imu_cnt, n_imu_cnt;
    logic [7:0]           r_bat_cnt, n_bat_cnt;

    logic                 w_frame_ok, w_frame_lost, w_rx_fs, w_sw;
    logic                 w_calibrated, w_arm_test, w_bat_nan;
    logic                 w_fresh, w_timeout, w_imu_bad, w_imu_invalid;
    logic                 w_bat_ok_level, w_bat_crit, w_bat_good;
    logic                 w_edge, w_centred, w_thr_low, w_clear;
    logic [8:0]           w_lost_inc;
    logic [TIME_BITS-1:0] w_elapsed;
    logic [15:0]          w_mag_roll, w_mag_pitch, w_mag_yaw, w_stick_lim;
    logic [4:0]           w_faults;
    logic                 w_latch_mid, w_active_mid;
    logic [5:0]           w_reason_mid;

    always_comb begin
        w_frame_ok   = i_item.radio_flags[0];
        w_frame_lost = i_item.radio_flags[1];
        w_rx_fs      = i_item.radio_flags[2];
        w_sw         = i_item.radio_flags[3];
        w_calibrated = i_item.misc_flags[0];
        w_arm_test   = i_item.misc_flags[1];
        w_bat_nan    = i_item.misc_flags[2];

        w_fresh      = w_frame_ok && (!r_have_frame || (i_frame_time_us > r_last_good));
        w_lost_inc   = {1'b0, r_lost_cnt} + 9'd1;

        n_have_frame = r_have_frame || w_fresh;
        n_last_good  = w_fresh ? i_frame_time_us : r_last_good;
        n_good_cnt   = (w_fresh && (r_good_cnt != 16'hFFFF)) ? r_good_cnt + 16'd1
                                                             : r_good_cnt;
        if (w_fresh) begin
            n_lost_cnt = 8'd0;
        end else if (w_frame_lost) begin
            if (w_lost_inc >= {1'b0, i_cfg.lost_frame_limit}) begin
                n_lost_cnt = i_cfg.lost_frame_limit;
            end else begin
                n_lost_cnt = w_lost_inc[7:0];
            end
        end else begin
            n_lost_cnt = r_lost_cnt;
        end

        w_elapsed = i_now_us - n_last_good;
        w_timeout = n_have_frame && (w_elapsed >= TIME_BITS'(i_cfg.link_timeout_us));

        w_imu_bad = !i_item.imu_status[0] || (i_item.imu_status[6:1] != 6'd0);
        if (w_imu_bad) begin
            n_imu_cnt = (r_imu_cnt < i_cfg.imu_debounce) ? r_imu_cnt + 8'd1 : r_imu_cnt;
        end else begin
            n_imu_cnt = 8'd0;
        end
        w_imu_invalid = n_imu_cnt >= i_cfg.imu_debounce;

        w_bat_ok_level = i_item.battery_mv >= i_cfg.battery_critical_mv;
        if (w_bat_nan || w_bat_ok_level) begin
            n_bat_cnt = 8'd0;
        end else if (r_bat_cnt < i_cfg.battery_critical_samples) begin
            n_bat_cnt = r_bat_cnt + 8'd1;
        end else begin
            n_bat_cnt = r_bat_cnt;
        end
        w_bat_crit = n_bat_cnt >= i_cfg.battery_critical_samples;
        w_bat_good = !w_bat_nan && w_bat_ok_level;

        w_edge        = w_sw && !r_switch_prev;
        n_switch_prev = w_sw;

        // magnitude of -32768 is 32768 as unsigned
        w_mag_roll  = i_item.roll_stick[15]  ? (~i_item.roll_stick + 16'd1)
                                             : i_item.roll_stick;
        w_mag_pitch = i_item.pitch_stick[15] ? (~i_item.pitch_stick + 16'd1)
                                             : i_item.pitch_stick;
        w_mag_yaw   = i_item.yaw_stick[15]   ? (~i_item.yaw_stick + 16'd1)
                                             : i_item.yaw_stick;
        w_stick_lim = {1'b0, i_cfg.stick_center_max};
        w_centred   = (w_mag_roll <= w_stick_lim) && (w_mag_pitch <= w_stick_lim)
                   && (w_mag_yaw <= w_stick_lim);
        w_thr_low   = $signed(i_item.throttle_stick)
                   <= $signed({1'b0, i_cfg.throttle_low_max});

        w_clear = w_edge && !r_boot_latch && w_fresh && w_thr_low && w_centred
               && !w_imu_invalid && w_bat_good;

        w_latch_mid  = w_clear ? 1'b0 : r_latch;
        w_active_mid = w_clear ? 1'b0 : r_active;
        w_reason_mid = w_clear ? 6'd0 : r_reason;

        w_faults = {w_bat_crit, w_bat_nan, w_imu_invalid, w_rx_fs, w_timeout};
        if (w_faults != 5'd0) begin
            n_latch  = 1'b1;
            n_active = 1'b1;
            n_reason = w_reason_mid | {1'b0, w_faults};
        end else begin
            n_latch  = w_latch_mid;
            n_active = w_active_mid;
            n_reason = w_reason_mid;
        end

        n_boot_latch = r_boot_latch;

        if (w_arm_test) begin
            if (!r_arm_test_prev) begin
                n_armed = (!n_latch && !r_boot_latch && !n_active) ? 1'b1 : r_armed;
            end else begin
                n_armed = r_armed && !n_latch && !r_boot_latch;
            end
        end else if (r_armed) begin
            n_armed = w_sw && !n_latch && !r_boot_latch && !w_imu_invalid;
        end else begin
            n_armed = w_fresh && w_sw && w_calibrated && !n_latch && !r_boot_latch
                   && (n_good_cnt >= i_cfg.min_good_frames) && w_thr_low && w_centred
                   && !w_imu_invalid && w_bat_good;
        end
        if (n_active) begin
            n_armed = 1'b0;
        end
        n_arm_test_prev = w_arm_test;

        if (i_item.action == ACT_BOOT) begin
            n_armed         = 1'b0;
            n_active        = 1'b0;
            n_arm_test_prev = 1'b0;
            n_switch_prev   = 1'b0;
            n_have_frame    = 1'b0;
            n_last_good     = '0;
            n_good_cnt      = 16'd0;
            n_lost_cnt      = 8'd0;
            n_imu_cnt       = 8'd0;
            n_bat_cnt       = 8'd0;
            if ((i_item.reset_cause >= RC_BROWNOUT) && (i_item.reset_cause <= RC_WDT)) begin
                n_boot_latch = 1'b1;
                n_latch      = 1'b1;
                n_reason     = REASON_BOOT;
            end else begin
                n_boot_latch = 1'b0;
                n_latch      = 1'b0;
                n_reason     = 6'd0;
            end
        end

        o_result.armed           = n_armed;
        o_result.failsafe_active = n_active;
        o_result.fault_latched   = n_latch;
        o_result.boot_latched    = n_boot_latch;
        o_result.reason_bits     = n_reason;
        o_result.lost_frames     = n_lost_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed         <= 1'b0;
            r_active        <= 1'b0;
            r_latch         <= 1'b0;
            r_boot_latch    <= 1'b0;
            r_arm_test_prev <= 1'b0;
            r_switch_prev   <= 1'b0;
            r_reason        <= 6'd0;
            r_last_good     <= '0;
            r_have_frame    <= 1'b0;
            r_good_cnt      <= 16'd0;
            r_lost_cnt      <= 8'd0;
            r_imu_cnt       <= 8'd0;
            r_bat_cnt       <= 8'd0;
        end else if (i_en) begin
            r_armed         <= n_armed;
            r_active        <= n_active;
            r_latch         <= n_latch;
            r_boot_latch    <= n_boot_latch;
            r_arm_test_prev <= n_arm_test_prev;
            r_switch_prev   <= n_switch_prev;
            r_reason        <= n_reason;
            r_last_good     <= n_last_good;
            r_have_frame    <= n_have_frame;
            r_good_cnt      <= n_good_cnt;
            r_lost_cnt      <= n_lost_cnt;
            r_imu_cnt       <= n_imu_cnt;
            r_bat_cnt       <= n_bat_cnt;
        end
    end

endmodule

`default_nettype wire

// File: hdl/flight_failsafe_arm_latch_core.sv
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    action, reset_cause, flags, times, sticks,
//                                                 imu_status, battery_mv, misc_flags
// out       output     o_out_valid / i_out_stall  armed, failsafe_active, fault_latched,
//                                                 boot_latched, reason_bits, lost_frames
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one transaction per cycle sustained while i_out_stall is low; input register, then result register
// the guard state is updated as an item moves from the input register into the result register
// synchronous active-low reset clears guard state and loads register defaults
// i_out_stall holds the result register and backs up into o_in_stall once the input
// register is also full; cfg writes are always ready

`default_nettype none

module flight_failsafe_arm_latch_core
    import fsal_pkg::*;
#(
    parameter int TIME_BITS = 64
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,

    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire                      i_action,
    input  wire [2:0]                i_reset_cause,
    input  wire [3:0]                i_radio_flags,
    input  wire [TIME_BITS-1:0]      i_frame_time_us,
    input  wire [TIME_BITS-1:0]      i_now_us,
    input  wire signed [15:0]        i_roll_stick,
    input  wire signed [15:0]        i_pitch_stick,
    input  wire signed [15:0]        i_yaw_stick,
    input  wire signed [15:0]        i_throttle_stick,
    input  wire [6:0]                i_imu_status,
    input  wire [15:0]               i_battery_mv,
    input  wire [2:0]                i_misc_flags,

    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output logic                     o_armed,
    output logic                     o_failsafe_active,
    output logic                     o_fault_latched,
    output logic                     o_boot_latched,
    output logic [5:0]               o_reason_bits,
    output logic [7:0]               o_lost_frames,

    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire [CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic                 r_in_valid;
    t_fsal_item           r_item;
    logic [TIME_BITS-1:0] r_frame_time;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_out_valid;
    t_fsal_result         r_result;

    t_fsal_cfg            w_cfg;
    t_fsal_result         w_result;
    logic                 w_adv;

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item.action         <= i_action;
            r_item.reset_cause    <= i_reset_cause;
            r_item.radio_flags    <= i_radio_flags;
            r_item.roll_stick     <= i_roll_stick;
            r_item.pitch_stick    <= i_pitch_stick;
            r_item.yaw_stick      <= i_yaw_stick;
            r_item.throttle_stick <= i_throttle_stick;
            r_item.imu_status     <= i_imu_status;
            r_item.battery_mv     <= i_battery_mv;
            r_item.misc_flags     <= i_misc_flags;
            r_frame_time          <= i_frame_time_us;
            r_now                 <= i_now_us;
        end
    end

    fsal_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    fsal_guard #(
        .TIME_BITS (TIME_BITS)
    ) u_guard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_adv),
        .i_item          (r_item),
        .i_frame_time_us (r_frame_time),
        .i_now_us        (r_now),
        .i_cfg           (w_cfg),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_armed           = r_result.armed;
    assign o_failsafe_active = r_result.failsafe_active;
    assign o_fault_latched   = r_result.fault_latched;
    assign o_boot_latched    = r_result.boot_latched;
    assign o_reason_bits     = r_result.reason_bits;
    assign o_lost_frames     = r_result.lost_frames;

    a_armed_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_armed && o_failsafe_active))
        else $error("armed while failsafe active");

    a_active_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_failsafe_active |-> o_fault_latched)
        else $error("failsafe active without fault latch");

    a_boot_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_boot_latched |-> o_fault_latched && o_reason_bits[5])
        else $error("boot latch without fault latch and boot reason");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && i_out_stall |=> r_in_valid)
        else $error("input transaction dropped under output stall");

endmodule

`default_nettype wire

// File: tb/tb.sv
module tb;
    import fsal_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 150;

    localparam int RF_OK       = 0;
    localparam int RF_LOST     = 1;
    localparam int RF_FAILSAFE = 2;
    localparam int RF_SWITCH   = 3;
    localparam int MF_CAL      = 0;
    localparam int MF_TEST     = 1;
    localparam int MF_NAN      = 2;
    localparam int IMU_VALID   = 0;

    localparam logic [6:0] IMU_NONFINITE = 7'h7E;
    localparam logic [2:0] RC_OTHER      = 3'd0;
    localparam logic [2:0] RC_UNKNOWN    = 3'd7;

    localparam logic [5:0] RSN_TIMEOUT  = 6'h01;
    localparam logic [5:0] RSN_RX       = 6'h02;
    localparam logic [5:0] RSN_IMU      = 6'h04;
    localparam logic [5:0] RSN_BAT_NAN  = 6'h08;
    localparam logic [5:0] RSN_BAT_CRIT = 6'h10;

    typedef struct {
        logic               action;
        logic [2:0]         cause;
        logic [3:0]         radio;
        logic [63:0]        frame_time;
        logic [63:0]        now;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] throttle;
        logic [6:0]         imu;
        logic [15:0]        mv;
        logic [2:0]         misc;
    } t_tick;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_action;
    logic [2:0]                i_reset_cause;
    logic [3:0]                i_radio_flags;
    logic [63:0]               i_frame_time_us;
    logic [63:0]               i_now_us;
    logic signed [15:0]        i_roll_stick;
    logic signed [15:0]        i_pitch_stick;
    logic signed [15:0]        i_yaw_stick;
    logic signed [15:0]        i_throttle_stick;
    logic [6:0]                i_imu_status;
    logic [15:0]               i_battery_mv;
    logic [2:0]                i_misc_flags;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic                      o_armed;
    logic                      o_failsafe_active;
    logic                      o_fault_latched;
    logic                      o_boot_latched;
    logic [5:0]                o_reason_bits;
    logic [7:0]                o_lost_frames;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    flight_failsafe_arm_latch_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_reset_cause    (i_reset_cause),
        .i_radio_flags    (i_radio_flags),
        .i_frame_time_us  (i_frame_time_us),
        .i_now_us         (i_now_us),
        .i_roll_stick     (i_roll_stick),
        .i_pitch_stick    (i_pitch_stick),
        .i_yaw_stick      (i_yaw_stick),
        .i_throttle_stick (i_throttle_stick),
        .i_imu_status     (i_imu_status),
        .i_battery_mv     (i_battery_mv),
        .i_misc_flags     (i_misc_flags),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_armed          (o_armed),
        .o_failsafe_active(o_failsafe_active),
        .o_fault_latched  (o_fault_latched),
        .o_boot_latched   (o_boot_latched),
        .o_reason_bits    (o_reason_bits),
        .o_lost_frames    (o_lost_frames),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // guard state mirror
    t_fsal_cfg   gcfg = '{32'd100000, 8'd3, 16'd3300, 8'd5, 15'd1638, 15'd819, 16'd10, 8'd10};
    logic        g_armed = 1'b0;
    logic        g_active = 1'b0;
    logic        g_latch = 1'b0;
    logic        g_boot_latch = 1'b0;
    logic        g_test_prev = 1'b0;
    logic        g_sw_prev = 1'b0;
    logic        g_have_frame = 1'b0;
    logic [5:0]  g_reason = '0;
    logic [63:0] g_last_ft = '0;
    logic [15:0] g_good_cnt = '0;
    logic [7:0]  g_lost = '0;
    logic [7:0]  g_imu_cnt = '0;
    logic [7:0]  g_bat_cnt = '0;

    t_tick        tick_q[$];
    t_fsal_result exp_status_q[$];
    t_tick        cur_tick;
    logic         in_taken = 1'b0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           idle_cycles = 0;
    int           n_err = 0;
    int           n_out = 0;
    int           n_boot = 0;
    int           n_armed = 0;
    int           n_latched = 0;
    int           n_setting = 1;

    logic [63:0]  fl_now = '0;
    logic         fl_sw = 1'b0;
    logic         fl_test = 1'b0;

    function automatic int stick_mag(logic signed [15:0] v);
        return (v < 0) ? -int'(v) : int'(v);
    endfunction

    function automatic t_fsal_result guard_predict(t_tick t);
        t_fsal_result res;
        logic fresh, timed_out, imu_bad, imu_inv, level_ok, bat_crit;
        logic sw, sw_rise, centred, thr_low, bat_good, nan_flag, test_req, calibrated;
        logic [8:0] lost_next;
        logic [5:0] why;
        if (t.action == ACT_BOOT) begin
            g_armed = 1'b0;
            g_active = 1'b0;
            g_latch = 1'b0;
            g_boot_latch = 1'b0;
            g_test_prev = 1'b0;
            g_sw_prev = 1'b0;
            g_have_frame = 1'b0;
            g_reason = '0;
            g_last_ft = '0;
            g_good_cnt = '0;
            g_lost = '0;
            g_imu_cnt = '0;
            g_bat_cnt = '0;
            if (t.cause >= RC_BROWNOUT && t.cause <= RC_WDT) begin
                g_boot_latch = 1'b1;
                g_latch = 1'b1;
                g_reason = REASON_BOOT;
            end
        end else begin
            sw = t.radio[RF_SWITCH];
            nan_flag = t.misc[MF_NAN];
            test_req = t.misc[MF_TEST];
            calibrated = t.misc[MF_CAL];

            fresh = t.radio[RF_OK] && (!g_have_frame || t.frame_time > g_last_ft);
            if (fresh) begin
                if (g_good_cnt != 16'hFFFF) g_good_cnt++;
                g_last_ft = t.frame_time;
                g_have_frame = 1'b1;
                g_lost = '0;
            end else if (t.radio[RF_LOST]) begin
                lost_next = {1'b0, g_lost} + 9'd1;
                if (lost_next >= {1'b0, gcfg.lost_frame_limit}) begin
                    lost_next = {1'b0, gcfg.lost_frame_limit};
                end
                g_lost = lost_next[7:0];
            end
            timed_out = g_have_frame &&
                        ((t.now - g_last_ft) >= {32'd0, gcfg.link_timeout_us});

            imu_bad = !t.imu[IMU_VALID] || ((t.imu & IMU_NONFINITE) != 0);
            if (imu_bad) begin
                if (g_imu_cnt < gcfg.imu_debounce) g_imu_cnt++;
            end else begin
                g_imu_cnt = '0;
            end
            imu_inv = g_imu_cnt >= gcfg.imu_debounce;

            level_ok = t.mv >= gcfg.battery_critical_mv;
            if (nan_flag || level_ok) begin
                g_bat_cnt = '0;
            end else if (g_bat_cnt < gcfg.battery_critical_samples) begin
                g_bat_cnt++;
            end
            bat_crit = g_bat_cnt >= gcfg.battery_critical_samples;

            sw_rise = sw && !g_sw_prev;
            g_sw_prev = sw;
            centred = stick_mag(t.roll) <= int'(gcfg.stick_center_max) &&
                      stick_mag(t.pitch) <= int'(gcfg.stick_center_max) &&
                      stick_mag(t.yaw) <= int'(gcfg.stick_center_max);
            thr_low = int'(t.throttle) <= int'(gcfg.throttle_low_max);
            bat_good = !nan_flag && level_ok;

            if (sw_rise && !g_boot_latch && fresh && thr_low && centred && !imu_inv &&
                bat_good) begin
                g_latch = 1'b0;
                g_active = 1'b0;
                g_reason = '0;
            end

            why = '0;
            if (timed_out) why |= RSN_TIMEOUT;
            if (t.radio[RF_FAILSAFE]) why |= RSN_RX;
            if (imu_inv) why |= RSN_IMU;
            if (nan_flag) why |= RSN_BAT_NAN;
            if (bat_crit) why |= RSN_BAT_CRIT;
            if (why != 0) begin
                g_latch = 1'b1;
                g_active = 1'b1;
                g_reason |= why;
            end

            if (test_req) begin
                if (!g_test_prev) begin
                    if (!g_latch && !g_boot_latch && !g_active) g_armed = 1'b1;
                end else begin
                    g_armed = g_armed && !g_latch && !g_boot_latch;
                end
            end else if (g_armed) begin
                g_armed = sw && !g_latch && !g_boot_latch && !imu_inv;
            end else begin
                g_armed = fresh && sw && calibrated && !g_latch && !g_boot_latch &&
                          g_good_cnt >= gcfg.min_good_frames && thr_low && centred &&
                          !imu_inv && bat_good;
            end
            if (g_active) g_armed = 1'b0;
            g_test_prev = test_req;
        end
        res.armed = g_armed;
        res.failsafe_active = g_active;
        res.fault_latched = g_latch;
        res.boot_latched = g_boot_latch;
        res.reason_bits = g_reason;
        res.lost_frames = g_lost;
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_tick rand_fields();
        t_tick t;
        t.action = ACT_UPDATE;
        t.cause = 3'($urandom);
        t.radio = 4'($urandom);
        t.frame_time = rand64();
        t.now = rand64();
        t.roll = 16'($urandom);
        t.pitch = 16'($urandom);
        t.yaw = 16'($urandom);
        t.throttle = 16'($urandom);
        t.imu = 7'($urandom);
        t.mv = 16'($urandom);
        t.misc = 3'($urandom);
        return t;
    endfunction

    function automatic t_tick boot_tick(logic [2:0] cause);
        t_tick t;
        t = rand_fields();
        t.action = ACT_BOOT;
        t.cause = cause;
        fl_now = ($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 200000)
                                              : rand64();
        fl_sw = 1'b0;
        fl_test = 1'b0;
        return t;
    endfunction

    function automatic t_tick good_tick(logic [63:0] ft, logic sw);
        t_tick t;
        t = rand_fields();
        t.radio = '0;
        t.radio[RF_OK] = 1'b1;
        t.radio[RF_SWITCH] = sw;
        t.frame_time = ft;
        t.now = ft;
        t.roll = '0;
        t.pitch = '0;
        t.yaw = '0;
        t.throttle = -16'sd16384;
        t.imu = 7'h01;
        t.mv = 16'd4000;
        t.misc = '0;
        t.misc[MF_CAL] = 1'b1;
        return t;
    endfunction

    function automatic logic signed [15:0] rand_stick(int lim);
        if ($urandom_range(0, 99) < 8) return 16'($urandom);
        return 16'(int'($urandom_range(0, 2 * lim)) - lim);
    endfunction

    // plausible control tick around the current flight clock
    function automatic t_tick flight_tick();
        t_tick t;
        int lim;
        t = rand_fields();
        if ($urandom_range(0, 19) == 0) fl_now += 64'($urandom);
        else fl_now += $urandom_range(1, 3000);
        if ($urandom_range(0, 24) == 0) fl_sw = !fl_sw;
        if ($urandom_range(0, 39) == 0) fl_test = !fl_test;
        t.now = fl_now;
        t.frame_time = ($urandom_range(0, 9) == 0) ? rand64() : fl_now - $urandom_range(0, 500);
        t.radio = '0;
        t.radio[RF_OK] = $urandom_range(0, 99) < 88;
        t.radio[RF_LOST] = $urandom_range(0, 99) < 25;
        t.radio[RF_FAILSAFE] = $urandom_range(0, 99) < 2;
        t.radio[RF_SWITCH] = fl_sw;
        lim = int'(gcfg.stick_center_max) + 40;
        t.roll = rand_stick(lim);
        t.pitch = rand_stick(lim);
        t.yaw = rand_stick(lim);
        if ($urandom_range(0, 99) < 85) begin
            t.throttle = 16'(int'($urandom_range(0, int'(gcfg.throttle_low_max) + 16384)) - 16384);
        end
        if ($urandom_range(0, 99) < 93) t.imu = 7'h01;
        if ($urandom_range(0, 99) < 90) t.mv = 16'($urandom_range(65535, gcfg.battery_critical_mv));
        else t.mv = 16'($urandom_range(0, gcfg.battery_critical_mv));
        t.misc = '0;
        t.misc[MF_CAL] = $urandom_range(0, 99) < 95;
        t.misc[MF_TEST] = fl_test;
        t.misc[MF_NAN] = $urandom_range(0, 99) < 2;
        return t;
    endfunction

    function automatic t_fsal_cfg rand_settings();
        t_fsal_cfg s;
        s.link_timeout_us = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1000, 200000);
        s.imu_debounce = 8'($urandom_range(1, 8));
        s.battery_critical_mv = 16'($urandom_range(3000, 3700));
        s.battery_critical_samples = 8'($urandom_range(1, 8));
        s.stick_center_max = 15'($urandom_range(200, 16384));
        s.throttle_low_max = 15'($urandom_range(0, 16384));
        s.min_good_frames = 16'($urandom_range(0, 30));
        s.lost_frame_limit = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                            : $urandom_range(1, 20));
        return s;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_cfg(t_fsal_cfg s);
        write_reg(CFG_LINK_TIMEOUT, s.link_timeout_us);
        write_reg(CFG_IMU_DEBOUNCE, 32'(s.imu_debounce));
        write_reg(CFG_BAT_CRIT_MV, 32'(s.battery_critical_mv));
        write_reg(CFG_BAT_CRIT_CNT, 32'(s.battery_critical_samples));
        write_reg(CFG_STICK_CENTER, 32'(s.stick_center_max));
        write_reg(CFG_THROTTLE_LOW, 32'(s.throttle_low_max));
        write_reg(CFG_MIN_FRAMES, 32'(s.min_good_frames));
        write_reg(CFG_LOST_LIMIT, 32'(s.lost_frame_limit));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        n_setting++;
    endtask

    task automatic wait_drained();
        while (tick_q.size() != 0 || i_in_valid || exp_status_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            in_taken = 1'b0;
            if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_tick = tick_q.pop_front();
                i_action <= cur_tick.action;
                i_reset_cause <= cur_tick.cause;
                i_radio_flags <= cur_tick.radio;
                i_frame_time_us <= cur_tick.frame_time;
                i_now_us <= cur_tick.now;
                i_roll_stick <= cur_tick.roll;
                i_pitch_stick <= cur_tick.pitch;
                i_yaw_stick <= cur_tick.yaw;
                i_throttle_stick <= cur_tick.throttle;
                i_imu_status <= cur_tick.imu;
                i_battery_mv <= cur_tick.mv;
                i_misc_flags <= cur_tick.misc;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_fsal_result want;
        logic fired;
        if (i_rst_n) begin
            fired = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                fired = 1'b1;
                case (i_cfg_index)
                    CFG_LINK_TIMEOUT: gcfg.link_timeout_us = i_cfg_data;
                    CFG_IMU_DEBOUNCE: gcfg.imu_debounce = i_cfg_data[7:0];
                    CFG_BAT_CRIT_MV:  gcfg.battery_critical_mv = i_cfg_data[15:0];
                    CFG_BAT_CRIT_CNT: gcfg.battery_critical_samples = i_cfg_data[7:0];
                    CFG_STICK_CENTER: gcfg.stick_center_max = i_cfg_data[14:0];
                    CFG_THROTTLE_LOW: gcfg.throttle_low_max = i_cfg_data[14:0];
                    CFG_MIN_FRAMES:   gcfg.min_good_frames = i_cfg_data[15:0];
                    CFG_LOST_LIMIT:   gcfg.lost_frame_limit = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                fired = 1'b1;
                in_taken = 1'b1;
                if (cur_tick.action == ACT_BOOT) n_boot++;
                exp_status_q.push_back(guard_predict(cur_tick));
            end
            if (o_out_valid && !i_out_stall) begin
                fired = 1'b1;
                n_out++;
                if (o_armed) n_armed++;
                if (o_fault_latched) n_latched++;
                if (exp_status_q.size() == 0) begin
                    $error("unexpected result transaction");
                    n_err++;
                end else begin
                    want = exp_status_q.pop_front();
                    check_field("armed", want.armed, o_armed);
                    check_field("failsafe_active", want.failsafe_active, o_failsafe_active);
                    check_field("fault_latched", want.fault_latched, o_fault_latched);
                    check_field("boot_latched", want.boot_latched, o_boot_latched);
                    check_field("reason_bits", want.reason_bits, o_reason_bits);
                    check_field("lost_frames", want.lost_frames, o_lost_frames);
                end
            end
            idle_cycles = fired ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_tick d;
        t_fsal_cfg s;
        int r;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_UPDATE;
        i_reset_cause = '0;
        i_radio_flags = '0;
        i_frame_time_us = '0;
        i_now_us = '0;
        i_roll_stick = '0;
        i_pitch_stick = '0;
        i_yaw_stick = '0;
        i_throttle_stick = '0;
        i_imu_status = '0;
        i_battery_mv = '0;
        i_misc_flags = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;

        // directed: boot causes, arming paths, every fault reason
        tick_q.push_back(boot_tick(RC_BROWNOUT));
        tick_q.push_back(boot_tick(RC_UNKNOWN));
        tick_q.push_back(boot_tick(RC_OTHER));
        for (int i = 0; i < 10; i++) tick_q.push_back(good_tick(64'(i * 100), 1'b0));
        tick_q.push_back(good_tick(64'd1000, 1'b1));
        d = good_tick(64'd1000, 1'b1);
        d.roll = -16'sd32768;
        d.radio[RF_LOST] = 1'b1;
        tick_q.push_back(d);
        d = good_tick(64'd1100, 1'b0);
        d.misc[MF_TEST] = 1'b1;
        d.pitch = 16'sd32767;
        tick_q.push_back(d);
        d = good_tick(64'd1200, 1'b0);
        d.misc[MF_TEST] = 1'b1;
        d.throttle = 16'sd32767;
        d.yaw = -16'sd32768;
        d.imu = 7'h7F;
        tick_q.push_back(d);
        d = good_tick(64'd1300, 1'b0);
        d.radio[RF_FAILSAFE] = 1'b1;
        d.imu = 7'h7F;
        tick_q.push_back(d);
        d = good_tick(64'd1400, 1'b1);
        d.imu = 7'h00;
        tick_q.push_back(d);
        d = good_tick(64'd1500, 1'b1);
        d.misc[MF_NAN] = 1'b1;
        tick_q.push_back(d);
        d = good_tick(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        d.now = 64'h1000;
        d.mv = '0;
        tick_q.push_back(d);
        for (int i = 0; i < 4; i++) begin
            d = good_tick(64'h0, 1'b0);
            d.radio = '0;
            d.radio[RF_LOST] = 1'b1;
            d.now = 64'd200000;
            d.mv = '0;
            tick_q.push_back(d);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: s = gcfg;
                1: s = '{32'd1, 8'd1, 16'd0, 8'd1, 15'd0, 15'd0, 16'd0, 8'd1};
                2: s = '{32'hFFFF_FFFF, 8'd255, 16'd65535, 8'd255, 15'd16384, 15'd16384,
                         16'd65535, 8'd255};
                3: begin
                    s = rand_settings();
                    s.link_timeout_us = '0;
                    s.imu_debounce = '0;
                    s.battery_critical_samples = '0;
                    s.lost_frame_limit = '0;
                end
                default: s = rand_settings();
            endcase
            if (ph != 0) program_cfg(s);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 60; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 60; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            tick_q.push_back(boot_tick(RC_OTHER));
            repeat (PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    tick_q.push_back(boot_tick(($urandom_range(0, 9) < 6) ? RC_OTHER
                                                                            : 3'($urandom)));
                end else if (r < 20) begin
                    tick_q.push_back(rand_fields());
                end else begin
                    tick_q.push_back(flight_tick());
                end
            end
        end

        wait_drained();
        $display("checked %0d result transactions over %0d register settings, %0d boots",
                 n_out, n_setting, n_boot);
        $display("%0d results came out armed and %0d with a fault latched", n_armed, n_latched);
        if (n_err == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
